FILE: design/hampel_outlier_filter_macros.svh
// Assertion macros for the hampel outlier filter checker.
// Expects signals named clock and reset in the scope of use.
`ifndef HAMPEL_OUTLIER_FILTER_MACROS_SVH
`define HAMPEL_OUTLIER_FILTER_MACROS_SVH

// Check a consequence in the next cycle, off during reset.
`define HOF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hampel filter: next-cycle check failed");

// Check a consequence in the same cycle, off during reset.
`define HOF_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hampel filter: same-cycle check failed");

// Check a consequence in the next cycle, active through reset.
`define HOF_ASSERT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("hampel filter: reset check failed");

`endif

FILE: design/hof_pkg.sv
// Package of the hampel outlier filter: constants, controller states,
// command and status structs shared by controller and datapath.
`default_nettype none
package hof_pkg;

   localparam int DATA_W    = 16;
   localparam int MIN_FILL  = 3;
   localparam logic [15:0] THRESHOLD_RESET = 16'd12288;
   localparam logic [15:0] SCALE_RESET     = 16'd6073;

   // Register index codes (paddr bit 2)
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_SCALE     = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_CHECK,
      ST_CAND,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_MEDIAN,
      ST_MAD,
      ST_MUL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic accept;      // capture input sample
      logic write;       // write sample into window, advance slot
      logic check;       // latch bypass flag, start value pass
      logic cand_issue;  // read candidate, clear rank counts
      logic scan_issue;  // read next compare entry
      logic decide;      // test candidate rank, advance candidate
      logic median;      // latch median, start deviation pass
      logic mad;         // latch MAD, deviation and threshold product
      logic mul;         // form full threshold product
      logic load_out;    // load result register
   } cmd_type;

   typedef struct packed {
      logic few;         // fewer than three samples filled
      logic j_last;      // last compare entry issued
      logic i_last;      // last candidate tested
      logic pass;        // 0: value pass, 1: deviation pass
      logic out_busy;    // result register occupied and not taken
   } status_type;

endpackage
`default_nettype wire

FILE: design/hof_ctrl.sv
// Controller of the hampel outlier filter: sequences the two rank-select
// passes and the threshold test. Uses hof_pkg.
`default_nettype none
module hof_ctrl
   import hof_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  status_type      status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.few ? ST_FINISH : ST_CAND;
         end
         ST_CAND: begin
            cmd.cand_issue = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.j_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (!status.i_last) state_in = ST_CAND;
            else if (status.pass) state_in = ST_MAD;
            else state_in = ST_MEDIAN;
         end
         ST_MEDIAN: begin
            cmd.median = 1'b1;
            state_in   = ST_CAND;
         end
         ST_MAD: begin
            cmd.mad  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

FILE: design/hof_datapath.sv
// Datapath of the hampel outlier filter: window memory, rank counting,
// median and MAD registers, threshold multiply and result register. Uses hof_pkg.
`default_nettype none
module hof_datapath
   import hof_pkg::*;
#(
   parameter int WINDOW = 7
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  wire logic [DATA_W-1:0]  sample_in,
   input  wire logic [15:0]        threshold,
   input  wire logic [15:0]        scale,
   input  wire logic               out_taken,
   output logic                    out_valid,
   output logic [DATA_W-1:0]       out_sample,
   output logic                    out_replaced
);

   localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW = $clog2(WINDOW + 1);

   logic [DATA_W-1:0] mem [WINDOW];
   logic [DATA_W-1:0] rd_ff;
   logic [IW-1:0]     raddr;

   logic [IW-1:0]     slot_ff, slot_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [IW-1:0]     i_ff, j_ff;
   logic [CW-1:0]     less_ff, eq_ff;
   logic              pass_ff, bypass_ff;
   logic              load_cand_ff, cmp_valid_ff;
   logic signed [16:0] cand_ff, lo_ff, hi_ff, val;
   logic signed [16:0] diff;
   logic [DATA_W-1:0] sample_ff, median_ff, mad_ff, dev_ff;
   logic [31:0]       prod_ff;
   logic [47:0]       rhs_ff;
   logic              out_valid_ff, out_replaced_ff;
   logic [DATA_W-1:0] out_sample_ff;

   logic [CW-1:0]     k1, k2;
   logic [CW:0]       top_rank;
   logic signed [17:0] mid_sum;
   logic signed [16:0] dev_diff;
   logic [16:0]       dev_abs;
   logic [47:0]       lhs;

   // Window memory with registered read
   assign raddr = cmd.cand_issue ? i_ff : j_ff;
   always_ff @(posedge clock) begin
      if (cmd.write) mem[slot_ff] <= sample_ff;
      rd_ff <= mem[raddr];
   end

   // Advance write slot and fill count
   assign slot_in = (slot_ff == IW'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
   assign fill_in = (fill_ff == CW'(WINDOW)) ? fill_ff : fill_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
         load_cand_ff <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else begin
         if (cmd.write) begin
            slot_ff <= slot_in;
            fill_ff <= fill_in;
         end
         if (cmd.load_out) out_valid_ff <= 1'b1;
         else if (out_taken) out_valid_ff <= 1'b0;
         load_cand_ff <= cmd.cand_issue;
         cmp_valid_ff <= cmd.scan_issue;
      end
   end

   // Map read data to the value under rank: sample or its deviation
   assign diff = $signed({rd_ff[15], rd_ff}) - $signed({median_ff[15], median_ff});
   always_comb begin
      if (pass_ff) val = diff[16] ? -diff : diff;
      else val = $signed({rd_ff[15], rd_ff});
   end

   // Rank targets and median sum
   assign k1       = (fill_ff - 1'b1) >> 1;
   assign k2       = fill_ff >> 1;
   assign top_rank = {1'b0, less_ff} + {1'b0, eq_ff};
   assign mid_sum  = {lo_ff[16], lo_ff} + {hi_ff[16], hi_ff};

   // Deviation of the current sample from the median
   assign dev_diff = $signed({sample_ff[15], sample_ff}) - $signed({median_ff[15], median_ff});
   assign dev_abs  = dev_diff[16] ? 17'(-dev_diff) : 17'(dev_diff);
   assign lhs      = {8'd0, dev_ff, 24'd0};

   // Datapath registers
   always_ff @(posedge clock) begin
      if (cmd.accept) sample_ff <= sample_in;
      if (cmd.check) begin
         bypass_ff <= (fill_ff < CW'(MIN_FILL));
         pass_ff   <= 1'b0;
         i_ff      <= '0;
      end
      if (cmd.cand_issue) begin
         j_ff    <= '0;
         less_ff <= '0;
         eq_ff   <= '0;
      end
      if (cmd.scan_issue) j_ff <= j_ff + 1'b1;
      if (load_cand_ff) cand_ff <= val;
      if (cmp_valid_ff) begin
         if (val < cand_ff) less_ff <= less_ff + 1'b1;
         if (val == cand_ff) eq_ff <= eq_ff + 1'b1;
      end
      if (cmd.decide) begin
         if (less_ff <= k1 && {1'b0, k1} < top_rank) lo_ff <= cand_ff;
         if (less_ff <= k2 && {1'b0, k2} < top_rank) hi_ff <= cand_ff;
         i_ff <= i_ff + 1'b1;
      end
      if (cmd.median) begin
         median_ff <= mid_sum[16:1];
         pass_ff   <= 1'b1;
         i_ff      <= '0;
      end
      if (cmd.mad) begin
         mad_ff  <= mid_sum[16:1];
         dev_ff  <= dev_abs[15:0];
         prod_ff <= {16'd0, threshold} * {16'd0, scale};
      end
      if (cmd.mul) rhs_ff <= {16'd0, prod_ff} * {32'd0, mad_ff};
      if (cmd.load_out) begin
         if (!bypass_ff && lhs > rhs_ff) begin
            out_sample_ff   <= median_ff;
            out_replaced_ff <= 1'b1;
         end else begin
            out_sample_ff   <= sample_ff;
            out_replaced_ff <= 1'b0;
         end
      end
   end

   // Status to the controller
   assign status.few      = (fill_ff < CW'(MIN_FILL));
   assign status.j_last   = (CW'(j_ff) == CW'(fill_ff - 1'b1));
   assign status.i_last   = (CW'(i_ff) == CW'(fill_ff - 1'b1));
   assign status.pass     = pass_ff;
   assign status.out_busy = out_valid_ff && !out_taken;

   assign out_valid    = out_valid_ff;
   assign out_sample   = out_sample_ff;
   assign out_replaced = out_replaced_ff;

endmodule
`default_nettype wire

FILE: design/hampel_outlier_filter.sv
// Hampel outlier filter: Q8.8 samples in, filtered samples out, one item at a time.
// Each item is written into the window and checked; with fewer than three samples
// filled it passes through, else two rank-count passes (values, then deviations
// from the median) test each filled entry as a candidate via the window's one read port.
// A new item is taken only after the last result is loaded into a free result register.
// Reset: synchronous, clears window fill, slot, result valid; registers to defaults.
`default_nettype none
module hampel_outlier_filter
   import hof_pkg::*;
#(
   parameter int WINDOW = 7
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] sample_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] sample_out
   output logic             rsp_tuser,   // [0] replaced
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cmd_type    cmd;
   status_type status;
   logic [15:0] threshold_ff, scale_ff;
   logic        csr_write;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         scale_ff     <= SCALE_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_SCALE) scale_ff <= csr_pwdata[15:0];
         else threshold_ff <= csr_pwdata[15:0];
      end
   end
   assign csr_prdata = {16'd0, (csr_paddr[2] == REG_THRESHOLD) ? threshold_ff : scale_ff};

   hof_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   hof_datapath #(.WINDOW(WINDOW)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .sample_in    (req_tdata),
      .threshold    (threshold_ff),
      .scale        (scale_ff),
      .out_taken    (rsp_tready),
      .out_valid    (rsp_tvalid),
      .out_sample   (rsp_tdata),
      .out_replaced (rsp_tuser)
   );

endmodule
`default_nettype wire

FILE: design/hof_checker.sv
// Port-level checker for the hampel outlier filter, bound to the top level.
// Uses the assertion macros header.
`default_nettype none
`include "hampel_outlier_filter_macros.svh"
module hof_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        csr_pready
);

   `HOF_ASSERT_RST(a_reset_empty, reset, !rsp_tvalid)
   `HOF_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   `HOF_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `HOF_ASSERT_NOW(a_pready_high, 1'b1, csr_pready)

endmodule

bind hampel_outlier_filter hof_checker u_hof_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);
`default_nettype wire

FILE: bench/hampel_outlier_filter_checker.sv
// Checker for the hampel outlier filter: watches the sample and result streams
// and the register port, predicts each result and compares. Uses hof_pkg.
`default_nettype none
module hampel_outlier_filter_checker
   import hof_pkg::*;
#(
   parameter int WINDOW = 7
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,
   input  wire logic        rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               fail_count,
   output int               pending_count
);

   typedef struct packed {
      logic [15:0] sample;
      logic        replaced;
   } filtered_t;

   logic signed [15:0] window_q [WINDOW];
   int                 slot_q;
   int                 fill_q;
   logic [15:0]        threshold_q;
   logic [15:0]        scale_q;
   filtered_t          filtered_q [$];

   // Sort ascending in place.
   function automatic void sort_values(ref int vals [WINDOW], input int n);
      int key;
      int j;
      for (int i = 1; i < n; i++) begin
         key = vals[i];
         j = i;
         while (j > 0 && vals[j-1] > key) begin
            vals[j] = vals[j-1];
            j--;
         end
         vals[j] = key;
      end
   endfunction

   // Middle of a sorted list; even count rounds toward minus infinity.
   function automatic int middle_of(ref int vals [WINDOW], input int n);
      int sum;
      if (n % 2 == 1) return vals[n/2];
      sum = vals[n/2-1] + vals[n/2];
      return sum >>> 1;
   endfunction

   // Insert one sample and work out its filtered result.
   function automatic filtered_t filter_sample(logic signed [15:0] sample);
      filtered_t   res;
      int          vals [WINDOW];
      int          devs [WINDOW];
      int          median;
      int          mad;
      int          dev;
      longint unsigned lhs;
      longint unsigned rhs;
      window_q[slot_q] = sample;
      slot_q = (slot_q + 1) % WINDOW;
      if (fill_q < WINDOW) fill_q++;
      res.sample = sample;
      res.replaced = 1'b0;
      if (fill_q < MIN_FILL) return res;
      for (int i = 0; i < fill_q; i++) vals[i] = int'(window_q[i]);
      sort_values(vals, fill_q);
      median = middle_of(vals, fill_q);
      for (int i = 0; i < fill_q; i++) begin
         dev = int'(window_q[i]) - median;
         devs[i] = dev < 0 ? -dev : dev;
      end
      sort_values(devs, fill_q);
      mad = middle_of(devs, fill_q);
      dev = int'(sample) - median;
      if (dev < 0) dev = -dev;
      lhs = longint'(dev) << 24;
      rhs = longint'(threshold_q) * longint'(scale_q) * longint'(mad);
      if (lhs > rhs) begin
         res.sample = median[15:0];
         res.replaced = 1'b1;
      end
      return res;
   endfunction

   assign pending_count = filtered_q.size();

   always @(posedge clock) begin
      filtered_t want;
      int        errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) window_q[i] = '0;
         slot_q = 0;
         fill_q = 0;
         threshold_q = THRESHOLD_RESET;
         scale_q = SCALE_RESET;
         filtered_q.delete();
         fail_count <= 0;
      end else begin
         // Track register writes.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_THRESHOLD) threshold_q = csr_pwdata[15:0];
            else scale_q = csr_pwdata[15:0];
         end
         // Predict each accepted item.
         if (req_tvalid && req_tready) filtered_q.push_back(filter_sample(req_tdata));
         // Compare each accepted result.
         if (rsp_tvalid && rsp_tready) begin
            if (filtered_q.size() == 0) begin
               $error("unexpected result item: sample_out %h", rsp_tdata);
               errs++;
            end else begin
               want = filtered_q.pop_front();
               if (rsp_tdata !== want.sample) begin
                  $error("sample_out: expected %h, actual %h", want.sample, rsp_tdata);
                  errs++;
               end
               if (rsp_tuser !== want.replaced) begin
                  $error("replaced: expected %b, actual %b", want.replaced, rsp_tuser);
                  errs++;
               end
            end
         end
         // Count this cycle's mismatches once.
         fail_count <= fail_count + errs;
      end
   end

endmodule
`default_nettype wire

FILE: bench/tb_hampel_outlier_filter.sv
// Testbench top for the hampel outlier filter: clock, reset, sample stimulus,
// register phases and verdict. Uses hof_pkg and hampel_outlier_filter_checker.
`default_nettype none
module tb_hampel_outlier_filter
   import hof_pkg::*;
();

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [15:0] sample_in
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [15:0] sample_out
   logic        rsp_tuser;   // [0] replaced
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_count;
   int          hold_off;
   int          base_level;

   hampel_outlier_filter #(.WINDOW(7)) u_top (.*);

   hampel_outlier_filter_checker #(.WINDOW(7)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Give up after a generous fixed time.
   initial begin
      #20000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stall the result side on a pattern of its own, with one long hold-off.
   initial begin
      rsp_tready = 1'b0;
      hold_off = 0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
            hold_off--;
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Write one register over the config port.
   task automatic write_reg(logic regsel, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {regsel, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Offer one sample and hold it until taken.
   task automatic send_sample(logic [15:0] sample);
      req_tvalid <= 1'b1;
      req_tdata <= sample;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid for a random gap.
   task automatic idle_gap(int most);
      int gap;
      gap = $urandom_range(0, most);
      if (gap == 0) return;
      req_tvalid <= 1'b0;
      repeat (gap) @(negedge clock);
   endtask

   // Wait until every result is in, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Mostly noisy values near a level, with occasional spikes.
   function automatic logic [15:0] pick_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'($urandom);
      if (r == 1) return 16'(base_level);
      if (r == 2) return (base_level > 0) ? 16'h7fff : 16'h8000;
      return 16'(base_level + $urandom_range(0, 64) - 32);
   endfunction

   // Run a random burst phase.
   task automatic random_phase(int count);
      int left;
      left = 0;
      for (int i = 0; i < count; i++) begin
         if (left == 0) begin
            idle_gap(6);
            left = $urandom_range(1, 12);
         end
         if (i % 40 == 0) base_level = $signed(16'($urandom)) / 4;
         send_sample(pick_sample());
         left--;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      base_level = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: passthrough of the first two, extremes, spikes, flat window.
      send_sample(16'h8000);
      send_sample(16'h7fff);
      send_sample(16'h0000);
      send_sample(16'h0100);
      send_sample(16'h0101);
      send_sample(16'h0100);
      send_sample(16'h7fff);
      send_sample(16'h0100);
      send_sample(16'h0100);
      send_sample(16'h0100);
      send_sample(16'h0100);
      send_sample(16'h0101);
      send_sample(16'hffff);
      send_sample(16'h8000);
      send_sample(16'h5555);
      send_sample(16'haaaa);
      drain();

      // Zero threshold: any deviation is an outlier; high bits dropped.
      write_reg(REG_THRESHOLD, 32'hffff_0000);
      for (int i = 0; i < 6; i++) send_sample(16'($urandom_range(0, 8)));
      drain();

      // Maximum threshold and zero scale.
      write_reg(REG_THRESHOLD, 32'h0000_ffff);
      write_reg(REG_SCALE, 32'h0000_0000);
      random_phase(40);
      drain();

      // Maximum both.
      write_reg(REG_SCALE, 32'h0000_ffff);
      random_phase(60);

      // Long result hold-off while samples keep coming.
      hold_off = 600;
      random_phase(30);
      drain();

      // Defaults, then small random settings.
      write_reg(REG_THRESHOLD, 32'd12288);
      write_reg(REG_SCALE, 32'd6073);
      random_phase(300);
      drain();
      write_reg(REG_THRESHOLD, 32'($urandom_range(0, 8192)));
      write_reg(REG_SCALE, {16'($urandom), 16'($urandom_range(1, 8192))});
      random_phase(250);
      drain();

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire
